/* rtl/u8enc_pkg.sv */
// Shared types, constants and encoding functions of the UTF-8 encoder.
`timescale 1ns / 1ps

package u8enc_pkg;

   localparam int CP_W          = 21;
   localparam int BYTE_W        = 8;
   localparam int LIMIT_W       = 16;
   localparam int LEN_W         = 3;
   localparam int MAX_BYTES     = 4;
   localparam int COUNT_BITS_DEF = 16;
   localparam int QUEUE_DEPTH_DEF = 2;

   localparam logic [CP_W-1:0] CP_1B_END = 21'h00_0080;
   localparam logic [CP_W-1:0] CP_2B_END = 21'h00_0800;
   localparam logic [CP_W-1:0] CP_3B_END = 21'h01_0000;
   localparam logic [CP_W-1:0] CP_MAX    = 21'h10_FFFF;

   localparam logic [BYTE_W-1:0] LEAD_2B   = 8'hC0;
   localparam logic [BYTE_W-1:0] LEAD_3B   = 8'hE0;
   localparam logic [BYTE_W-1:0] LEAD_4B   = 8'hF0;
   localparam logic [BYTE_W-1:0] CONT_MARK = 8'h80;
   localparam logic [BYTE_W-1:0] SIX_MASK  = 8'h3F;
   localparam logic [BYTE_W-1:0] TERM_BYTE = 8'h00;

   // one queued job: payload bytes in send order, payload count, terminator flag
   typedef struct packed {
      logic [MAX_BYTES-1:0][BYTE_W-1:0] bytes;
      logic [LEN_W-1:0]                 n_payload;
      logic                             eos;
   } cmd_type;

   // front status seen by the top level checks
   typedef struct packed {
      logic count_zero;
      logic truncated;
   } front_stat_type;

   // encoded length, zero when the value is beyond the code space
   function automatic logic [LEN_W-1:0] enc_len(input logic [CP_W-1:0] cp);
      logic [LEN_W-1:0] n;
      if (cp < CP_1B_END)       n = LEN_W'(1);
      else if (cp < CP_2B_END)  n = LEN_W'(2);
      else if (cp < CP_3B_END)  n = LEN_W'(3);
      else if (cp <= CP_MAX)    n = LEN_W'(4);
      else                      n = LEN_W'(0);
      return n;
   endfunction

   function automatic logic [BYTE_W-1:0] cont(input logic [5:0] six);
      return CONT_MARK | {2'b00, six};
   endfunction

   // UTF-8 bytes, element 0 goes out first; unused elements are zero
   function automatic logic [MAX_BYTES-1:0][BYTE_W-1:0] encode(input logic [CP_W-1:0] cp);
      logic [MAX_BYTES-1:0][BYTE_W-1:0] b;
      b = '0;
      if (cp < CP_1B_END) begin
         b[0] = cp[BYTE_W-1:0];
      end else if (cp < CP_2B_END) begin
         b[0] = LEAD_2B | (SIX_MASK & {3'b000, cp[10:6]});
         b[1] = cont(cp[5:0]);
      end else if (cp < CP_3B_END) begin
         b[0] = LEAD_3B | {4'h0, cp[15:12]};
         b[1] = cont(cp[11:6]);
         b[2] = cont(cp[5:0]);
      end else begin
         b[0] = LEAD_4B | {5'b00000, cp[20:18]};
         b[1] = cont(cp[17:12]);
         b[2] = cont(cp[11:6]);
         b[3] = cont(cp[5:0]);
      end
      return b;
   endfunction

endpackage

/* rtl/u8enc_if.sv */
// Handshake channel interfaces of the UTF-8 encoder.
`timescale 1ns / 1ps

interface u8enc_req_if;
   logic                         valid;
   logic                         ready;
   logic [u8enc_pkg::CP_W-1:0]   code_point;
   logic                         end_of_string;
   modport source (output valid, code_point, end_of_string, input ready);
   modport sink   (input valid, code_point, end_of_string, output ready);
endinterface

interface u8enc_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [u8enc_pkg::BYTE_W-1:0] out_byte;
   logic                         is_last;
   modport source (output valid, out_byte, is_last, input ready);
   modport sink   (input valid, out_byte, is_last, output ready);
endinterface

interface u8enc_csr_if;
   logic                          valid;
   logic                          ready;
   logic [u8enc_pkg::LIMIT_W-1:0] byte_limit;
   modport source (output valid, byte_limit, input ready);
   modport sink   (input valid, byte_limit, output ready);
endinterface

/* rtl/u8enc_front.sv */
// Front end: takes code points, applies the byte limit, issues byte jobs.
`timescale 1ns / 1ps

module u8enc_front #(
   parameter int COUNT_BITS = u8enc_pkg::COUNT_BITS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   u8enc_req_if.sink                       req,
   input  logic [u8enc_pkg::LIMIT_W-1:0]   byte_limit,
   input  logic                            q_full,
   output logic                            q_push,
   output u8enc_pkg::cmd_type              q_cmd,
   output u8enc_pkg::front_stat_type       stat
);

   localparam int SUM_W = (COUNT_BITS + 1 > u8enc_pkg::LIMIT_W + 1) ?
                          COUNT_BITS + 1 : u8enc_pkg::LIMIT_W + 1;
   localparam logic [SUM_W-1:0] COUNT_MAX = SUM_W'({COUNT_BITS{1'b1}});

   logic [COUNT_BITS-1:0]        bytes_sent_ff, bytes_sent_in;
   logic                         truncated_ff, truncated_in;
   logic [u8enc_pkg::LEN_W-1:0]  n;
   logic [SUM_W-1:0]             sum;
   logic                         accept, take, over, emit;

   always_comb begin
      n      = u8enc_pkg::enc_len(req.code_point);
      sum    = SUM_W'(bytes_sent_ff) + SUM_W'(n);
      take   = (n != '0) && !truncated_ff;
      over   = (byte_limit != '0) && (sum > SUM_W'(byte_limit));
      emit   = take && !over;
      accept = req.valid && req.ready;

      q_cmd.bytes     = u8enc_pkg::encode(req.code_point);
      q_cmd.n_payload = emit ? n : '0;
      q_cmd.eos       = req.end_of_string;
      // nothing to queue for a dropped or skipped mid-string character
      q_push          = accept && (emit || req.end_of_string);

      bytes_sent_in = bytes_sent_ff;
      truncated_in  = truncated_ff;
      if (accept) begin
         if (req.end_of_string) begin
            bytes_sent_in = '0;
            truncated_in  = 1'b0;
         end else if (take && over) begin
            truncated_in  = 1'b1;
         end else if (emit) begin
            bytes_sent_in = (sum > COUNT_MAX) ? {COUNT_BITS{1'b1}} : sum[COUNT_BITS-1:0];
         end
      end
   end

   assign req.ready       = !q_full;
   assign stat.count_zero = (bytes_sent_ff == '0);
   assign stat.truncated  = truncated_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         bytes_sent_ff <= '0;
         truncated_ff  <= 1'b0;
      end else begin
         bytes_sent_ff <= bytes_sent_in;
         truncated_ff  <= truncated_in;
      end
   end

endmodule

/* rtl/u8enc_queue.sv */
// Short job queue between front and back, flip-flop storage.
`timescale 1ns / 1ps

module u8enc_queue #(
   parameter int DEPTH = u8enc_pkg::QUEUE_DEPTH_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  u8enc_pkg::cmd_type  push_cmd,
   input  logic                pop,
   output logic                full,
   output logic                not_empty,
   output u8enc_pkg::cmd_type  head
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

   u8enc_pkg::cmd_type  mem_ff [DEPTH];
   logic [PTR_W-1:0]    wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]    count_ff, count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + PTR_W'(1);
      if (pop)  rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + PTR_W'(1);
      if (push && !pop)      count_in = count_ff + CNT_W'(1);
      else if (pop && !push) count_in = count_ff - CNT_W'(1);
   end

   assign full      = (count_ff == CNT_W'(DEPTH));
   assign not_empty = (count_ff != '0);
   assign head      = mem_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) mem_ff[wr_ptr_ff] <= push_cmd;
   end

endmodule

/* rtl/u8enc_back.sv */
// Back end: serializes queued jobs into words on the result channel.
`timescale 1ns / 1ps

module u8enc_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                q_not_empty,
   input  u8enc_pkg::cmd_type  q_head,
   output logic                q_pop,
   u8enc_rsp_if.source         rsp
);

   localparam int LEN_W = u8enc_pkg::LEN_W;

   logic [LEN_W-1:0]              idx_ff, idx_in, total;
   logic                          valid_ff, valid_in;
   logic [u8enc_pkg::BYTE_W-1:0]  byte_ff, byte_in;
   logic                          last_ff, last_in;
   logic                          load, in_term;

   always_comb begin
      total   = q_head.n_payload + LEN_W'(q_head.eos);
      load    = q_not_empty && (!valid_ff || rsp.ready);
      q_pop   = load && (idx_ff == total - LEN_W'(1));
      in_term = (idx_ff >= q_head.n_payload);

      idx_in = idx_ff;
      if (load) idx_in = q_pop ? '0 : idx_ff + LEN_W'(1);

      valid_in = load || (valid_ff && !rsp.ready);
      byte_in  = byte_ff;
      last_in  = last_ff;
      if (load) begin
         byte_in = in_term ? u8enc_pkg::TERM_BYTE : q_head.bytes[idx_ff[1:0]];
         last_in = in_term;
      end
   end

   assign rsp.valid    = valid_ff;
   assign rsp.out_byte = byte_ff;
   assign rsp.is_last  = last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         idx_ff   <= idx_in;
         valid_ff <= valid_in;
      end
      byte_ff <= byte_in;
      last_ff <= last_in;
   end

endmodule

/* rtl/utf8_encoder_with_byte_limit_unit.sv */
// Top level of the UTF-8 encoder with per-string byte limit.
`timescale 1ns / 1ps

// Takes one code point word per cycle on req_chan while the job queue has
// room and sends UTF-8 bytes, one word per cycle while the sink is ready,
// on rsp_chan. A character costs one output word per byte (1 to 4), plus
// the zero terminator word (is_last set) after the final character of a
// string; the byte-wide result port sets the sustained rate. Characters
// dropped by the limit or above 0x10FFFF are taken on the input and give no
// payload byte. The front end accepts a word whenever the job queue
// (QUEUE_DEPTH entries) has room, so input keeps flowing while the back end
// drains a multi-byte character or waits on a stalled sink. With the pipeline
// empty, a word's first byte passes the job queue, then the output register.
// byte_limit is written through csr_chan (always ready) and caps payload
// bytes per string, zero meaning no limit; write it only while the block is
// idle. Reset is synchronous and clears the limit, the count and the queue.

module utf8_encoder_with_byte_limit_unit #(
   parameter int COUNT_BITS  = u8enc_pkg::COUNT_BITS_DEF,
   parameter int QUEUE_DEPTH = u8enc_pkg::QUEUE_DEPTH_DEF
) (
   input  logic          clock,
   input  logic          reset,
   u8enc_req_if.sink     req_chan,
   u8enc_rsp_if.source   rsp_chan,
   u8enc_csr_if.sink     csr_chan
);

   logic [u8enc_pkg::LIMIT_W-1:0]  byte_limit_ff, byte_limit_in;
   logic                           q_full, q_push, q_pop, q_not_empty;
   u8enc_pkg::cmd_type             q_cmd, q_head;
   u8enc_pkg::front_stat_type      front_stat;

   // config register, write always accepted
   assign csr_chan.ready = 1'b1;
   assign byte_limit_in  = csr_chan.valid ? csr_chan.byte_limit : byte_limit_ff;

   always_ff @(posedge clock) begin
      if (reset) byte_limit_ff <= '0;
      else       byte_limit_ff <= byte_limit_in;
   end

   // front: length, limit check, count update
   u8enc_front #(.COUNT_BITS(COUNT_BITS)) u_front (
      .clock      (clock),
      .reset      (reset),
      .req        (req_chan),
      .byte_limit (byte_limit_ff),
      .q_full     (q_full),
      .q_push     (q_push),
      .q_cmd      (q_cmd),
      .stat       (front_stat)
   );

   // decouples input acceptance from byte serialization
   u8enc_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_cmd  (q_cmd),
      .pop       (q_pop),
      .full      (q_full),
      .not_empty (q_not_empty),
      .head      (q_head)
   );

   // back: one byte per word into the output register
   u8enc_back u_back (
      .clock       (clock),
      .reset       (reset),
      .q_not_empty (q_not_empty),
      .q_head      (q_head),
      .q_pop       (q_pop),
      .rsp         (rsp_chan)
   );

   // end of string clears the running count and the cut flag
   a_eos_clears: assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready && req_chan.end_of_string) |=>
         (front_stat.count_zero && !front_stat.truncated))
      else $error("count not cleared after end of string");

   // the queue never takes a job while full
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      q_push |-> !q_full)
      else $error("job pushed into full queue");

   // the closing word is always the zero terminator
   a_term_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.is_last) |-> (rsp_chan.out_byte == u8enc_pkg::TERM_BYTE))
      else $error("terminator word not zero");

   // nothing leaves the block right after reset
   a_reset_quiet: assert property (@(posedge clock)
      $past(reset) |-> !rsp_chan.valid)
      else $error("result valid after reset");

endmodule
